// ===== rtl/core/next_fit_free_list_allocator_top_macros.svh =====
// assertion macros for the allocator checker
`ifndef NEXT_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define NEXT_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define NFFA_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, clocked on clk, off during reset
`define NFFA_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

// next-cycle implication that also holds across reset
`define NFFA_AST_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== rtl/core/nffa_pkg.sv =====
// shared types and constants for the free-list allocator
package nffa_pkg;

  localparam int HEAP_UNITS = 8192;
  localparam int UNIT_SHIFT = 4;
  localparam int IDX_W      = 14;
  localparam int SUM_W      = 15;
  localparam int STEP_W     = 16;
  localparam int WALK_LIMIT = 4 * (HEAP_UNITS + 2);
  localparam int GROW_RESET = 1024;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_FAIL   = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [31:0]      nbytes;
    logic [IDX_W-1:0] block_addr;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] payload_addr;
    logic             status;
  } out_t;

  typedef struct packed {
    logic             re;
    logic             we_link;
    logic             we_size;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] link;
    logic [IDX_W-1:0] size;
  } mem_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] link;
    logic [IDX_W-1:0] size;
  } mem_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_A_START, S_A_LINK, S_A_CHK, S_CARVE, S_CARVE2, S_A_GROW,
    S_A_RELINK, S_A_GLINK, S_I_START, S_I_WALK, S_I_RDHB, S_I_RDNX, S_I_MERGE,
    S_I_WCUR, S_DONE
  } state_t;

endpackage

// ===== rtl/core/nffa_hdr_mem.sv =====
// single-port header store, link and size per unit, registered read
module nffa_hdr_mem (
  input  logic               clk,
  input  nffa_pkg::mem_req_t req,
  output nffa_pkg::mem_rsp_t rsp
);
  import nffa_pkg::*;

  logic [IDX_W-1:0] link_mem [0:HEAP_UNITS];
  logic [IDX_W-1:0] size_mem [0:HEAP_UNITS];
  logic [IDX_W-1:0] rd_link;
  logic [IDX_W-1:0] rd_size;
  logic             rd_oor;
  logic             in_range;

  assign in_range = ({1'b0, req.addr} <= (IDX_W+1)'(HEAP_UNITS));

  always_ff @(posedge clk) begin
    if (req.we_link && in_range) begin
      link_mem[req.addr] <= req.link;
    end
    if (req.we_size && in_range) begin
      size_mem[req.addr] <= req.size;
    end
    if (req.re) begin
      rd_oor <= !in_range;
      if (in_range) begin
        rd_link <= link_mem[req.addr];
        rd_size <= size_mem[req.addr];
      end
    end
  end

  // units beyond the arena read as zero
  assign rsp.link = rd_oor ? '0 : rd_link;
  assign rsp.size = rd_oor ? '0 : rd_size;
endmodule

// ===== rtl/core/nffa_alu.sv =====
// shared add/subtract unit, top bit is carry or borrow
module nffa_alu (
  input  logic [nffa_pkg::SUM_W-1:0] a,
  input  logic [nffa_pkg::SUM_W-1:0] b,
  input  logic                       sub,
  output logic [nffa_pkg::SUM_W:0]   y
);
  import nffa_pkg::*;

  assign y = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
endmodule

// ===== rtl/core/nffa_seq.sv =====
// sequencer for allocate and free walks over the header store
module nffa_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  nffa_pkg::in_t                  item,
  input  logic [nffa_pkg::IDX_W-1:0]     grow,
  input  logic                           out_free,
  output logic                           idle,
  output logic                           done,
  output nffa_pkg::out_t                 res,
  output nffa_pkg::mem_req_t             mreq,
  input  nffa_pkg::mem_rsp_t             mrsp
);
  import nffa_pkg::*;

  state_t            state, state_next;
  logic [IDX_W-1:0]  rover, brk, need, cur, prev, szr, g, hb, nx, hblink, hbsz, cursz;
  logic [SUM_W-1:0]  sumr;
  logic [STEP_W-1:0] steps, isteps;
  logic              started, big, low, from_alloc;

  logic [SUM_W-1:0]  alu_a, alu_b;
  logic              alu_sub;
  logic [SUM_W:0]    alu_y;

  logic [28:0]       need_calc;
  logic              free_ok, borrow, exact, over, iover, found, grow_ok, upper;

  nffa_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y));

  assign need_calc = 29'(item.nbytes >> UNIT_SHIFT)
                   + 29'(|item.nbytes[UNIT_SHIFT-1:0]) + 29'd1;
  assign free_ok = started && (item.block_addr >= IDX_W'(2))
                 && ({1'b0, item.block_addr} <= (IDX_W+1)'(HEAP_UNITS));
  assign borrow  = alu_y[SUM_W];
  assign exact   = !borrow && (alu_y[SUM_W-1:0] == '0);
  assign over    = ({1'b0, steps} >= (STEP_W+1)'(WALK_LIMIT));
  assign iover   = ({1'b0, isteps} >= (STEP_W+1)'(WALK_LIMIT));
  assign found   = ((hb > cur) && (hb < mrsp.link))
                 || ((cur >= mrsp.link) && ((hb > cur) || (hb < mrsp.link)));
  assign grow_ok = (alu_y <= (SUM_W+1)'(HEAP_UNITS + 1));
  assign upper   = (sumr == {1'b0, nx});

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (item.cmd == CMD_ALLOC) begin
            state_next = !started ? S_INIT : ((need_calc > 29'(HEAP_UNITS)) ? S_DONE : S_A_START);
          end else begin
            state_next = free_ok ? S_I_START : S_DONE;
          end
        end
      end
      S_INIT:     state_next = big ? S_DONE : S_A_START;
      S_A_START:  state_next = S_A_LINK;
      S_A_LINK:   state_next = S_A_CHK;
      S_A_CHK: begin
        if (!borrow) begin
          state_next = exact ? S_DONE : S_CARVE;
        end else if (cur == rover) begin
          state_next = S_A_GROW;
        end else if (over) begin
          state_next = S_DONE;
        end
      end
      S_CARVE:    state_next = S_CARVE2;
      S_CARVE2:   state_next = S_DONE;
      S_A_GROW:   state_next = grow_ok ? S_I_START : S_DONE;
      S_A_RELINK: state_next = S_A_GLINK;
      S_A_GLINK:  state_next = over ? S_DONE : S_A_CHK;
      S_I_START:  state_next = S_I_WALK;
      S_I_WALK: begin
        if (found) begin
          state_next = S_I_RDHB;
        end else if (iover) begin
          state_next = S_DONE;
        end
      end
      S_I_RDHB:   state_next = S_I_RDNX;
      S_I_RDNX:   state_next = S_I_MERGE;
      S_I_MERGE:  state_next = S_I_WCUR;
      S_I_WCUR:   state_next = from_alloc ? S_A_RELINK : S_DONE;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory port and shared adder
  always_comb begin
    mreq    = '0;
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_INIT: begin
        mreq.we_link = 1'b1;
        mreq.we_size = 1'b1;
      end
      S_A_START, S_A_RELINK, S_I_START: begin
        mreq.re   = 1'b1;
        mreq.addr = rover;
      end
      S_A_LINK: begin
        mreq.re   = 1'b1;
        mreq.addr = mrsp.link;
      end
      S_A_CHK: begin
        alu_a   = SUM_W'(mrsp.size);
        alu_b   = SUM_W'(need);
        alu_sub = 1'b1;
        if (exact) begin
          mreq.we_link = 1'b1;
          mreq.addr    = prev;
          mreq.link    = mrsp.link;
        end else if (borrow && (cur != rover) && !over) begin
          mreq.re   = 1'b1;
          mreq.addr = mrsp.link;
        end
      end
      S_CARVE: begin
        alu_a        = SUM_W'(cur);
        alu_b        = SUM_W'(szr);
        mreq.we_size = 1'b1;
        mreq.addr    = cur;
        mreq.size    = szr;
      end
      S_CARVE2: begin
        mreq.we_size = 1'b1;
        mreq.addr    = cur;
        mreq.size    = need;
      end
      S_A_GROW: begin
        alu_a = SUM_W'(brk);
        alu_b = SUM_W'(g);
        if (grow_ok) begin
          mreq.we_size = 1'b1;
          mreq.addr    = brk;
          mreq.size    = g;
        end
      end
      S_A_GLINK: begin
        mreq.re   = !over;
        mreq.addr = mrsp.link;
      end
      S_I_WALK: begin
        mreq.re   = found || !iover;
        mreq.addr = found ? hb : mrsp.link;
      end
      S_I_RDHB: begin
        alu_a     = SUM_W'(hb);
        alu_b     = SUM_W'(mrsp.size);
        mreq.re   = 1'b1;
        mreq.addr = nx;
      end
      S_I_RDNX: begin
        alu_a     = SUM_W'(hbsz);
        alu_b     = SUM_W'(mrsp.size);
        mreq.re   = 1'b1;
        mreq.addr = cur;
      end
      S_I_MERGE: begin
        alu_a        = SUM_W'(cur);
        alu_b        = SUM_W'(mrsp.size);
        mreq.we_link = 1'b1;
        mreq.we_size = 1'b1;
        mreq.addr    = hb;
        mreq.link    = hblink;
        mreq.size    = hbsz;
      end
      S_I_WCUR: begin
        alu_a        = SUM_W'(cursz);
        alu_b        = SUM_W'(hbsz);
        mreq.we_link = 1'b1;
        mreq.we_size = 1'b1;
        mreq.addr    = cur;
        mreq.link    = low ? hblink : hb;
        mreq.size    = low ? alu_y[IDX_W-1:0] : cursz;
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rover   <= '0;
      started <= 1'b0;
      brk     <= IDX_W'(1);
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            need       <= need_calc[IDX_W-1:0];
            big        <= (need_calc > 29'(HEAP_UNITS));
            hb         <= item.block_addr - IDX_W'(1);
            from_alloc <= 1'b0;
            res        <= '{payload_addr: '0,
                            status: (item.cmd == CMD_ALLOC) ? ST_FAIL : ST_OK};
          end
        end
        S_INIT: begin
          rover   <= '0;
          started <= 1'b1;
        end
        S_A_START: begin
          prev  <= rover;
          steps <= '0;
        end
        S_A_LINK: cur <= mrsp.link;
        S_A_CHK: begin
          if (!borrow) begin
            rover <= prev;
            szr   <= alu_y[IDX_W-1:0];
            if (exact) begin
              res <= '{payload_addr: cur + IDX_W'(1), status: ST_OK};
            end
          end else if (cur == rover) begin
            g <= (grow > need) ? grow : need;
          end else begin
            prev  <= cur;
            cur   <= mrsp.link;
            steps <= steps + STEP_W'(1);
          end
        end
        S_CARVE:  cur <= alu_y[IDX_W-1:0];
        S_CARVE2: res <= '{payload_addr: cur + IDX_W'(1), status: ST_OK};
        S_A_GROW: begin
          if (grow_ok) begin
            brk        <= alu_y[IDX_W-1:0];
            hb         <= brk;
            from_alloc <= 1'b1;
          end
        end
        S_A_RELINK: prev <= rover;
        S_A_GLINK: begin
          cur   <= mrsp.link;
          steps <= steps + STEP_W'(1);
        end
        S_I_START: begin
          cur    <= rover;
          isteps <= '0;
        end
        S_I_WALK: begin
          nx <= mrsp.link;
          if (!found) begin
            cur    <= mrsp.link;
            isteps <= isteps + STEP_W'(1);
          end
        end
        S_I_RDHB: begin
          hbsz <= mrsp.size;
          sumr <= alu_y[SUM_W-1:0];
        end
        S_I_RDNX: begin
          // merge with the upper neighbour
          hbsz   <= upper ? alu_y[IDX_W-1:0] : hbsz;
          hblink <= upper ? mrsp.link : nx;
        end
        S_I_MERGE: begin
          cursz <= mrsp.size;
          low   <= (alu_y == (SUM_W+1)'(hb));
        end
        S_I_WCUR: rover <= cur;
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== rtl/core/next_fit_free_list_allocator_top.sv =====
// Next-fit free-list allocator over a unit arena with coalescing free.
// One transaction is worked at a time on a single-port header store; in_ready is high only
// while the sequencer is idle. An allocate visits list entries from the rover, carves the
// tail of a block when the fit is not exact, and on the first allocate sets up the sentinel.
// Each arena growth examines entries during the address-ordered insert, and a free examines
// entries likewise. An ignored free or an oversized request goes straight to the result,
// after the sentinel set-up on the first allocate. A finished transaction waits until the
// output register is free. The single memory port allows one header access per cycle. The
// result sits in an output register, so the next transaction is taken while it waits. The
// header store needs no clearing pass after reset; grow_units is written on cfg_wr_en.
module next_fit_free_list_allocator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nffa_pkg::in_t              in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nffa_pkg::out_t             out_item,
  input  logic                       cfg_wr_en,
  input  logic [nffa_pkg::IDX_W-1:0] cfg_wr_data
);
  import nffa_pkg::*;

  logic [IDX_W-1:0] grow_units;
  logic             seq_idle;
  logic             seq_done;
  logic             out_free;
  out_t             seq_res;
  mem_req_t         mreq;
  mem_rsp_t         mrsp;

  // result slot frees when empty or being taken
  assign out_free = !out_valid || out_ready;
  assign in_ready = seq_idle;

  // grow size register
  always_ff @(posedge clk) begin
    if (rst) begin
      grow_units <= IDX_W'(GROW_RESET);
    end else if (cfg_wr_en) begin
      grow_units <= cfg_wr_data;
    end
  end

  nffa_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid && in_ready),
    .item     (in_item),
    .grow     (grow_units),
    .out_free (out_free),
    .idle     (seq_idle),
    .done     (seq_done),
    .res      (seq_res),
    .mreq     (mreq),
    .mrsp     (mrsp)
  );

  nffa_hdr_mem u_mem (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  // output register, one transaction deep
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_item <= seq_res;
    end
  end
endmodule

// ===== rtl/core/nffa_chk.sv =====
// port-level checker for the allocator, bound to the top level
`include "next_fit_free_list_allocator_top_macros.svh"

module nffa_chk (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input nffa_pkg::out_t out_item
);
  import nffa_pkg::*;

  `NFFA_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `NFFA_AST_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `NFFA_AST_IMP(a_fail_no_addr, out_valid && (out_item.status == ST_FAIL),
                out_item.payload_addr == '0)
  `NFFA_AST_RST(a_reset_empty, rst, !out_valid)
endmodule

bind next_fit_free_list_allocator_top nffa_chk u_chk (.*);
